@@ hdl/pet_pkg.sv @@
// Package for the priority eviction table: function codes, status codes and widths.
// Used by pet_store and priority_eviction_table; depends on nothing.
`default_nettype none
package pet_pkg;
   localparam int TOTAL_BITS = 37;
   localparam int TDATA_IN_BITS = 152;
   localparam int TDATA_OUT_BITS = 144;

   typedef enum logic [1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_UNLOAD = 2'd1,
      FUNC_SETPRI = 2'd2,
      FUNC_SELECT = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL = 2'd2,
      STAT_RSVD = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0] status;
      logic cand_valid;
      logic [63:0] cand_key;
      logic [TOTAL_BITS-1:0] freed;
      logic last;
      logic [TOTAL_BITS-1:0] in_use;
   } rsp_type;
endpackage
`default_nettype wire

@@ hdl/pet_store.sv @@
// Entry memory of the eviction table: key, size and priority per slot.
// One write port, one read port with a registered read. Depends on pet_pkg.
`default_nettype none
module pet_store
   import pet_pkg::*;
#(
   parameter int ENTRIES = 32,
   parameter int KEY_BITS = 64,
   parameter int SIZE_BITS = 32,
   parameter int PRIORITY_BITS = 16,
   localparam int IDX_BITS = $clog2(ENTRIES),
   localparam int ROW_BITS = KEY_BITS + SIZE_BITS + PRIORITY_BITS
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [IDX_BITS-1:0] wr_addr,
   input wire logic [ROW_BITS-1:0] wr_data,
   input wire logic [IDX_BITS-1:0] rd_addr,
   output logic [ROW_BITS-1:0] rd_data
);
   logic [ROW_BITS-1:0] mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ hdl/priority_eviction_table.sv @@
// Top level of the priority eviction table: sequencer, used bits and output register.
// Instantiates pet_store; depends on pet_pkg.
//
// Unload, set priority and a select with something to list walk the entry memory one
// slot per cycle; load, and a select with nothing to list, do not scan. Select makes
// one full scan of the memory read port per candidate emitted, and holds each result
// back while the result register still holds one the consumer has not taken. One item
// is worked at a time; the result register lets the next item be accepted and its scan
// start while a result waits.
`default_nettype none
module priority_eviction_table
   import pet_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32,
   parameter int KEY_BITS = 64,
   parameter int SIZE_BITS = 32,
   parameter int PRIORITY_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // func[1:0], object_key[65:2], object_bytes[97:66], new_priority[113:98],
   // bytes_needed[150:114], zero fill
   input wire logic [TDATA_IN_BITS-1:0] req_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // status[1:0], candidate_valid[2], candidate_key[66:3], freed_so_far[103:67],
   // bytes_in_use[140:104], zero fill
   output logic [TDATA_OUT_BITS-1:0] rsp_tdata,
   output logic rsp_tlast
);
   localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);
   localparam int ROW_BITS = KEY_BITS + SIZE_BITS + PRIORITY_BITS;
   localparam int LIMIT = 32;
   localparam int NBITS = 6;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DONE, S_EMIT
   } state_type;

   state_type state_ff;
   func_type func_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [PRIORITY_BITS-1:0] pri_ff;
   logic [TOTAL_BITS-1:0] need_ff, freed_ff, total_ff;
   logic [TABLE_ENTRIES-1:0] used_ff, taken_ff;
   logic [CNT_BITS-1:0] addr_ff;
   logic [CNT_BITS-1:0] rd_idx_ff;
   logic rd_vld_ff;
   logic found_ff;
   logic [IDX_BITS-1:0] best_ff;
   logic [KEY_BITS-1:0] bkey_ff;
   logic [SIZE_BITS-1:0] bsize_ff;
   logic [PRIORITY_BITS-1:0] bpri_ff;
   logic [NBITS-1:0] count_ff;
   rsp_type out_ff;
   logic out_vld_ff;

   logic wr_en;
   logic [IDX_BITS-1:0] wr_addr;
   logic [ROW_BITS-1:0] wr_data, rd_data;
   logic [KEY_BITS-1:0] r_key;
   logic [SIZE_BITS-1:0] r_size;
   logic [PRIORITY_BITS-1:0] r_pri;
   logic [IDX_BITS-1:0] ridx;
   logic [IDX_BITS-1:0] free_idx;
   logic free_any;

   assign {r_key, r_size, r_pri} = rd_data;
   assign ridx = rd_idx_ff[IDX_BITS-1:0];

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_BITS'(i);
         end
      end
   end

   pet_store #(
      .ENTRIES(TABLE_ENTRIES), .KEY_BITS(KEY_BITS),
      .SIZE_BITS(SIZE_BITS), .PRIORITY_BITS(PRIORITY_BITS)
   ) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(addr_ff[IDX_BITS-1:0]), .rd_data(rd_data)
   );

   logic can_out;
   logic out_fire;
   assign can_out = !out_vld_ff || rsp_tready;
   assign out_fire = can_out && (state_ff == S_DONE || state_ff == S_EMIT);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast = out_ff.last;
   assign rsp_tdata = TDATA_OUT_BITS'({out_ff.in_use, out_ff.freed, out_ff.cand_key,
                                       out_ff.cand_valid, out_ff.status});

   logic cand_better;
   logic cand_ok;
   always_comb begin
      cand_ok = rd_vld_ff && used_ff[ridx] && !taken_ff[ridx];
      cand_better = !found_ff || ($signed(r_pri) < $signed(bpri_ff)) ||
                    (r_pri == bpri_ff && r_size > bsize_ff);
   end

   logic [TOTAL_BITS:0] sum_w;
   logic [TOTAL_BITS-1:0] freed_next;
   always_comb begin
      sum_w = {1'b0, freed_ff} + (TOTAL_BITS+1)'(bsize_ff);
      freed_next = sum_w[TOTAL_BITS] ? TOTAL_MAX : sum_w[TOTAL_BITS-1:0];
   end

   logic [TOTAL_BITS:0] add_w;
   logic [TOTAL_BITS-1:0] load_total;
   always_comb begin
      add_w = {1'b0, total_ff} + (TOTAL_BITS+1)'(req_tdata[66 +: SIZE_BITS]);
      load_total = add_w[TOTAL_BITS] ? TOTAL_MAX : add_w[TOTAL_BITS-1:0];
   end

   logic scan_end;
   assign scan_end = rd_vld_ff && (rd_idx_ff == CNT_BITS'(TABLE_ENTRIES - 1));
   logic hit;
   assign hit = rd_vld_ff && used_ff[ridx] && r_key == key_ff && !found_ff;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = free_idx;
      wr_data = {req_tdata[2 +: KEY_BITS], req_tdata[66 +: SIZE_BITS],
                 PRIORITY_BITS'(0)};
      if (state_ff == S_IDLE && req_tvalid &&
          func_type'(req_tdata[1:0]) == FUNC_LOAD && free_any) begin
         wr_en = 1'b1;
      end else if (state_ff == S_SCAN && func_ff == FUNC_SETPRI && hit) begin
         wr_en = 1'b1;
         wr_addr = ridx;
         wr_data = {r_key, r_size, pri_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         total_ff <= '0;
         out_vld_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_fire || (out_vld_ff && !rsp_tready);
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  func_ff <= func_type'(req_tdata[1:0]);
                  key_ff <= req_tdata[2 +: KEY_BITS];
                  pri_ff <= PRIORITY_BITS'($signed(req_tdata[113:98]));
                  need_ff <= req_tdata[150:114];
                  freed_ff <= '0;
                  count_ff <= '0;
                  taken_ff <= '0;
                  found_ff <= (func_type'(req_tdata[1:0]) == FUNC_LOAD) && free_any;
                  addr_ff <= '0;
                  rd_vld_ff <= 1'b0;
                  if (func_type'(req_tdata[1:0]) == FUNC_LOAD) begin
                     if (free_any) begin
                        used_ff[free_idx] <= 1'b1;
                        total_ff <= load_total;
                     end
                     state_ff <= S_EMIT;
                  end else if (func_type'(req_tdata[1:0]) == FUNC_SELECT &&
                               (req_tdata[150:114] == '0 || used_ff == '0)) begin
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (addr_ff != CNT_BITS'(TABLE_ENTRIES)) addr_ff <= addr_ff + 1'b1;
               rd_vld_ff <= (addr_ff != CNT_BITS'(TABLE_ENTRIES));
               rd_idx_ff <= addr_ff;
               if (func_ff == FUNC_SELECT) begin
                  if (cand_ok && cand_better) begin
                     found_ff <= 1'b1;
                     best_ff <= ridx;
                     bkey_ff <= r_key;
                     bsize_ff <= r_size;
                     bpri_ff <= r_pri;
                  end
               end else if (hit) begin
                  found_ff <= 1'b1;
                  if (func_ff == FUNC_UNLOAD) begin
                     used_ff[ridx] <= 1'b0;
                     total_ff <= (total_ff >= TOTAL_BITS'(r_size)) ?
                                 total_ff - TOTAL_BITS'(r_size) : '0;
                  end
               end
               if (scan_end) state_ff <= S_DONE;
            end
            S_DONE: begin
               if (can_out) begin
                  rd_vld_ff <= 1'b0;
                  addr_ff <= '0;
                  if (func_ff == FUNC_SELECT) begin
                     // emit best; go on if more needed, below limit, entries left
                     taken_ff[best_ff] <= 1'b1;
                     freed_ff <= freed_next;
                     count_ff <= count_ff + 1'b1;
                     out_ff.status <= STAT_OK;
                     out_ff.cand_valid <= 1'b1;
                     out_ff.cand_key <= 64'(bkey_ff);
                     out_ff.freed <= freed_next;
                     out_ff.in_use <= total_ff;
                     found_ff <= 1'b0;
                     if (freed_next >= need_ff || count_ff == NBITS'(LIMIT - 1) ||
                         (used_ff & ~taken_ff) == (TABLE_ENTRIES'(1) << best_ff)) begin
                        out_ff.last <= 1'b1;
                        state_ff <= S_IDLE;
                     end else begin
                        out_ff.last <= 1'b0;
                        state_ff <= S_SCAN;
                     end
                  end else begin
                     out_ff.status <= found_ff ? STAT_OK : STAT_NOT_FOUND;
                     out_ff.cand_valid <= 1'b0;
                     out_ff.cand_key <= '0;
                     out_ff.freed <= '0;
                     out_ff.last <= 1'b1;
                     out_ff.in_use <= total_ff;
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_EMIT: begin
               if (can_out) begin
                  out_ff.status <= (func_ff == FUNC_LOAD && !found_ff) ? STAT_FULL : STAT_OK;
                  out_ff.cand_valid <= 1'b0;
                  out_ff.cand_key <= '0;
                  out_ff.freed <= '0;
                  out_ff.last <= 1'b1;
                  out_ff.in_use <= total_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ hdl/pet_checker.sv @@
// Port checker for the priority eviction table, bound to the top level.
// Depends on priority_eviction_table ports only.
`default_nettype none
module pet_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [143:0] rsp_tdata,
   input wire logic rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
   a_noval_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tlast)
      else $error("non-candidate result not last");
   a_noval_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[103:3] == '0)
      else $error("non-candidate result carries key or freed bytes");
   a_cand_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1:0] == 2'd0)
      else $error("candidate with error status");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind priority_eviction_table pet_checker u_pet_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for priority_eviction_table: load, unload, set priority and
// eviction candidate selection over a stream port, checked against a behavioral table.
// Depends on pet_pkg and priority_eviction_table.
`timescale 1ns / 100ps
module tb
   import pet_pkg::*;
();

   localparam int ENTRIES = 32;
   localparam int CAND_MAX = 32;
   localparam logic [36:0] TOTAL_MAX = 37'h1F_FFFF_FFFF;
   localparam longint CYCLE_LIMIT = 64'd3_000_000;

   typedef struct packed {
      logic [1:0] status;
      logic valid;
      logic [63:0] key;
      logic [36:0] freed;
      logic last;
      logic [36:0] in_use;
   } result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [TDATA_IN_BITS-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [TDATA_OUT_BITS-1:0] rsp_tdata;
   logic rsp_tlast;

   priority_eviction_table uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   // shadow table
   logic tab_used [ENTRIES];
   logic [63:0] tab_key [ENTRIES];
   logic [31:0] tab_bytes [ENTRIES];
   logic signed [15:0] tab_pri [ENTRIES];
   logic [36:0] usage;

   logic [TDATA_IN_BITS-1:0] pending_items[$];
   result_type expected_results[$];
   int errors = 0;
   int offered_count = 0;
   int total_items = 0;
   bit stim_done = 0;
   bit hold_off = 0;
   longint cycles = 0;
   logic [63:0] keys_seen[$];

   function automatic void add_expected(result_type r);
      expected_results = {expected_results, r};
   endfunction

   function automatic void add_pending(logic [TDATA_IN_BITS-1:0] d);
      pending_items = {pending_items, d};
   endfunction

   function automatic void add_key(logic [63:0] k);
      keys_seen = {keys_seen, k};
   endfunction

   function automatic logic [36:0] add_sat(logic [36:0] a, logic [31:0] b);
      logic [37:0] s;
      s = {1'b0, a} + b;
      return s > {1'b0, TOTAL_MAX} ? TOTAL_MAX : s[36:0];
   endfunction

   function automatic result_type plain_result(status_type st);
      result_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      r.in_use = usage;
      return r;
   endfunction

   task automatic predict_table(logic [TDATA_IN_BITS-1:0] d);
      func_type f;
      logic [63:0] key;
      logic [31:0] nbytes;
      logic signed [15:0] pri;
      logic [36:0] needed, freed;
      logic taken [ENTRIES];
      int slot, best, n;
      result_type r;
      f = func_type'(d[1:0]);
      key = d[65:2];
      nbytes = d[97:66];
      pri = d[113:98];
      needed = d[150:114];
      slot = -1;
      case (f)
         FUNC_LOAD: begin
            for (int i = ENTRIES - 1; i >= 0; i--) if (!tab_used[i]) slot = i;
            if (slot < 0) add_expected(plain_result(STAT_FULL));
            else begin
               tab_used[slot] = 1;
               tab_key[slot] = key;
               tab_bytes[slot] = nbytes;
               tab_pri[slot] = 0;
               usage = add_sat(usage, nbytes);
               add_expected(plain_result(STAT_OK));
            end
         end
         FUNC_UNLOAD, FUNC_SETPRI: begin
            for (int i = ENTRIES - 1; i >= 0; i--)
               if (tab_used[i] && tab_key[i] == key) slot = i;
            if (slot < 0) add_expected(plain_result(STAT_NOT_FOUND));
            else begin
               if (f == FUNC_UNLOAD) begin
                  usage = usage >= tab_bytes[slot] ? usage - tab_bytes[slot] : '0;
                  tab_used[slot] = 0;
               end else tab_pri[slot] = pri;
               add_expected(plain_result(STAT_OK));
            end
         end
         default: begin
            freed = '0;
            n = 0;
            foreach (taken[i]) taken[i] = 0;
            while (n < CAND_MAX && freed < needed) begin
               best = -1;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (!tab_used[i] || taken[i]) continue;
                  if (best < 0 || tab_pri[i] < tab_pri[best] ||
                      (tab_pri[i] == tab_pri[best] && tab_bytes[i] > tab_bytes[best]))
                     best = i;
               end
               if (best < 0) break;
               taken[best] = 1;
               freed = add_sat(freed, tab_bytes[best]);
               r = plain_result(STAT_OK);
               r.valid = 1;
               r.key = tab_key[best];
               r.freed = freed;
               r.last = 0;
               add_expected(r);
               n++;
            end
            if (n == 0) add_expected(plain_result(STAT_OK));
            else expected_results[$].last = 1;
         end
      endcase
   endtask

   function automatic logic [TDATA_IN_BITS-1:0] pack_item(func_type f, logic [63:0] key,
         logic [31:0] nbytes, logic [15:0] pri, logic [36:0] needed);
      logic [TDATA_IN_BITS-1:0] d;
      d = '0;
      d[1:0] = f;
      d[65:2] = key;
      d[97:66] = nbytes;
      d[113:98] = pri;
      d[150:114] = needed;
      return d;
   endfunction

   function automatic logic [63:0] rand_key();
      if (keys_seen.size() > 0 && $urandom_range(0, 3) != 0)
         return keys_seen[$urandom_range(0, keys_seen.size() - 1)];
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [31:0] rand_bytes();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 255);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [36:0] rand_needed();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return TOTAL_MAX - $urandom_range(0, 1);
         2: return {5'($urandom()), 32'($urandom())};
         default: return 37'($urandom_range(0, 32'h3FFF_FFFF)) << $urandom_range(0, 5);
      endcase
   endfunction

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      logic [63:0] k;
      func_type f;
      int sel;
      // directed: empty select, zero need, not found, full table, duplicates, extremes
      add_pending(pack_item(FUNC_SELECT, '0, '0, '0, TOTAL_MAX));
      add_pending(pack_item(FUNC_UNLOAD, 64'h5, '0, '0, '0));
      add_pending(pack_item(FUNC_SETPRI, 64'h5, '0, 16'h7FFF, '0));
      for (int i = 0; i < 34; i++) begin
         k = (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : (i == 1 ? 64'h0 : 64'(i % 20));
         add_pending(pack_item(FUNC_LOAD, k, (i < 8) ? 32'hFFFF_FFFF : 32'(i),
            '0, '0));
         add_key(k);
      end
      add_pending(pack_item(FUNC_SETPRI, 64'h3, '0, 16'h8000, '0));
      add_pending(pack_item(FUNC_SETPRI, 64'hFFFF_FFFF_FFFF_FFFF, '0,
         16'h7FFF, '0));
      add_pending(pack_item(FUNC_SELECT, '0, '0, '0, '0));
      add_pending(pack_item(FUNC_SELECT, '0, '0, '0, TOTAL_MAX));
      add_pending(pack_item(FUNC_SELECT, '0, '0, '0, 37'd100));
      add_pending(pack_item(FUNC_UNLOAD, 64'h3, '0, '0, '0));
      add_pending(pack_item(FUNC_UNLOAD, 64'h0, '0, '0, '0));
      for (int i = 0; i < 430; i++) begin
         sel = $urandom_range(0, 9);
         f = sel < 3 ? FUNC_LOAD : sel < 5 ? FUNC_UNLOAD : sel < 7 ? FUNC_SETPRI :
             FUNC_SELECT;
         k = (f == FUNC_LOAD && $urandom_range(0, 1)) ? {$urandom(), $urandom()} :
             rand_key();
         if (f == FUNC_LOAD) add_key(k);
         add_pending(pack_item(f, k, rand_bytes(),
            $urandom_range(0, 3) == 0 ? 16'(32'h7FFF + $urandom_range(0, 1)) :
            16'($urandom_range(0, 15) - 8), rand_needed()));
      end
      total_items = pending_items.size();
      stim_done = 1;
   end

   // driver
   int send_wait = 0;
   initial begin
      reset = 1;
      foreach (tab_used[i]) tab_used[i] = 0;
      usage = '0;
      repeat (10) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_table(req_tdata);
            offered_count++;
         end
         if (req_tvalid && !req_tready) begin
            // hold
         end else if (send_wait > 0) begin
            req_tvalid <= 0;
            send_wait <= send_wait - 1;
         end else if (pending_items.size() > 0) begin
            req_tvalid <= 1;
            req_tdata <= pending_items.pop_front();
            send_wait <= (offered_count % 100 < 30) ? 0 : $urandom_range(0, 8);
         end else req_tvalid <= 0;
      end
   end

   // long receiver stall
   int hold_cycles = 0;
   bit hold_started = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_started && offered_count >= 60) begin
            hold_started <= 1;
            hold_off <= 1;
            hold_cycles <= 600;
         end else if (hold_cycles > 1) begin
            hold_cycles <= hold_cycles - 1;
         end else if (hold_off) begin
            hold_off <= 0;
            hold_cycles <= 0;
         end
      end
   end

   // monitor
   int recv_wait = 0;
   int wait_next;
   result_type got;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         recv_wait <= 0;
      end else begin
         wait_next = (recv_wait > 0) ? recv_wait - 1 : 0;
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[1:0];
            got.valid = rsp_tdata[2];
            got.key = rsp_tdata[66:3];
            got.freed = rsp_tdata[103:67];
            got.in_use = rsp_tdata[140:104];
            got.last = rsp_tlast;
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected item %p", got);
            end else if (got !== expected_results[0]) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %p actual %p", expected_results[0], got);
               void'(expected_results.pop_front());
            end else void'(expected_results.pop_front());
            wait_next = (offered_count % 100 < 30) ? 0 : $urandom_range(0, 8);
         end
         recv_wait <= wait_next;
         rsp_tready <= !hold_off && wait_next == 0;
      end
   end

   initial begin
      @(negedge reset);
      while (!(stim_done && pending_items.size() == 0 && offered_count == total_items &&
               expected_results.size() == 0) && cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         repeat (200) @(posedge clock);
         if (errors == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
         else
            $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end
endmodule
